// File: hw/rtl/mspt_pkg.sv
// Shared types, codes and sizes of the multi-slot periodic timer.
package mspt_pkg;

    // Table size and derived index width
    localparam int SLOTS  = 8;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Fixed field widths
    localparam int CMD_W  = 4;
    localparam int SLOT_W = 3;
    localparam int TIME_W = 32;
    localparam int REP_W  = 15;
    localparam int ELAP_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK          = 4'd0,
        CMD_ATTACH        = 4'd1,
        CMD_DETACH        = 4'd2,
        CMD_PAUSE         = 4'd3,
        CMD_RESUME        = 4'd4,
        CMD_RESTART       = 4'd5,
        CMD_CHANGE_PERIOD = 4'd6,
        CMD_SET_REPEATS   = 4'd7,
        CMD_QUERY         = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_REJECT     = 2'd1,
        STAT_NOT_IN_USE = 2'd2,
        STAT_FULL       = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPTIME,
        ST_ADD,
        ST_SUB,
        ST_FIND,
        ST_EXEC,
        ST_FLUSH
    } state_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic in_valid;
        logic cmd_tick;
        logic cmd_attach;
        logic live;
        logic find_hit;
        logic fire;
        logic stall;
        logic out_free;
        logic pend_valid;
    } seq_sts_t;

    // Control from the sequencer to the datapath
    typedef struct packed {
        state_t           state;
        logic [IDX_W-1:0] idx;
        logic             idx_end;
        logic             ready;
    } seq_ctl_t;

endpackage

// File: hw/rtl/multi_slot_periodic_timer_top.sv
// Top level of the multi-slot periodic timer: slot table, datapath, result staging.
//
//   channel | direction | handshake         | payload
//   s_      | in        | s_valid / s_ready | command, slot, period, repeats, elapsed
//   m_      | out       | m_valid / m_ready | status, slot, fired, finished, repeats,
//           |           |                   | pause flag, uptime, last
//
// Tick: uptime update, then each running slot takes one saturating add and one
// compare-subtract pass through the single shared 32-bit adder.
// Attach: free-slot scan, one slot a cycle; other commands: one execute step.
// Reset clears slot use and pause flags, uptime and all valid flags.
// A firing waits while the staged item and the output register are both full.
module multi_slot_periodic_timer_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mspt_pkg::CMD_W-1:0]   s_command,
    input  logic [mspt_pkg::SLOT_W-1:0]  s_slot,
    input  logic [mspt_pkg::TIME_W-1:0]  s_period_ms,
    input  logic [mspt_pkg::REP_W-1:0]   s_repeat_count,
    input  logic [mspt_pkg::ELAP_W-1:0]  s_elapsed_ms,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [mspt_pkg::SLOT_W-1:0]  m_timer_slot,
    output logic                         m_fired,
    output logic                         m_finished,
    output logic [mspt_pkg::REP_W-1:0]   m_repeats_left,
    output logic                         m_is_paused,
    output logic [mspt_pkg::TIME_W-1:0]  m_uptime_ms,
    output logic                         m_last
);
    import mspt_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic                fired;
        logic                finished;
        logic [REP_W-1:0]    reps;
        logic                paused;
        logic [TIME_W-1:0]   uptime;
    } res_t;

    seq_sts_t sts;
    seq_ctl_t ctl;

    // Slot table
    logic [SLOTS-1:0]  in_use_reg;
    logic [SLOTS-1:0]  paused_reg;
    logic [TIME_W-1:0] acc_reg [SLOTS];
    logic [TIME_W-1:0] per_reg [SLOTS];
    logic [REP_W-1:0]  rep_reg [SLOTS];

    // Latched command
    logic [CMD_W-1:0]  cmd_reg;
    logic [SLOT_W-1:0] cmd_slot_reg;
    logic [TIME_W-1:0] period_reg;
    logic [REP_W-1:0]  reps_reg;
    logic [ELAP_W-1:0] elapsed_reg;

    logic [TIME_W-1:0] uptime_reg, uptime_next;
    res_t              pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    res_t              out_reg;
    logic              out_last_reg;
    logic              m_valid_reg, m_valid_next;

    logic              accept;
    logic [IDX_W-1:0]  slot_idx;
    logic [IDX_W-1:0]  rd_idx;
    logic              slot_ok;
    logic              cur_use;
    logic              cur_pause;
    logic [TIME_W-1:0] cur_acc;
    logic [TIME_W-1:0] cur_per;
    logic [REP_W-1:0]  cur_rep;
    logic [REP_W-1:0]  rep_new;
    logic              fin;
    logic              out_free;
    logic              stall;
    logic              period_zero;

    logic [TIME_W-1:0] op_a, op_b, op_sum;
    logic              op_sub, op_carry;

    logic              tbl_we;
    logic              tbl_use_n;
    logic              tbl_pause_n;
    logic [TIME_W-1:0] tbl_acc_n;
    logic [TIME_W-1:0] tbl_per_n;
    logic [REP_W-1:0]  tbl_rep_n;
    logic              out_load;
    logic              out_last;
    res_t              res;

    assign accept      = s_valid && ctl.ready;
    assign slot_idx    = IDX_W'(cmd_slot_reg);
    assign slot_ok     = (32'(cmd_slot_reg) < SLOTS);
    assign rd_idx      = (ctl.state == ST_EXEC) ? slot_idx : ctl.idx;
    assign cur_use     = in_use_reg[rd_idx];
    assign cur_pause   = paused_reg[rd_idx];
    assign cur_acc     = acc_reg[rd_idx];
    assign cur_per     = per_reg[rd_idx];
    assign cur_rep     = rep_reg[rd_idx];
    assign fin         = (cur_rep == REP_W'(1));
    assign rep_new     = (cur_rep != '0) ? cur_rep - 1'b1 : cur_rep;
    assign out_free    = !m_valid_reg || m_ready;
    assign stall       = pend_valid_reg && !out_free;
    assign period_zero = (period_reg == '0);

    // Status toward the sequencer
    always_comb begin
        sts.in_valid   = s_valid;
        sts.cmd_tick   = (s_command == CMD_TICK);
        sts.cmd_attach = (s_command == CMD_ATTACH);
        sts.live       = cur_use && !cur_pause;
        sts.find_hit   = period_zero || !cur_use;
        sts.fire       = op_carry;
        sts.stall      = stall;
        sts.out_free   = out_free;
        sts.pend_valid = pend_valid_reg;
    end

    mspt_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .ctl     (ctl)
    );

    mspt_addsub u_addsub (
        .op_a     (op_a),
        .op_b     (op_b),
        .op_sub   (op_sub),
        .op_sum   (op_sum),
        .op_carry (op_carry)
    );

    // Datapath: table update, staged item and output load per sequencer step
    always_comb begin
        tbl_we          = 1'b0;
        tbl_use_n       = cur_use;
        tbl_pause_n     = cur_pause;
        tbl_acc_n       = cur_acc;
        tbl_per_n       = cur_per;
        tbl_rep_n       = cur_rep;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_load        = 1'b0;
        out_last        = 1'b0;
        uptime_next     = uptime_reg;
        op_a            = cur_acc;
        op_b            = TIME_W'(elapsed_reg);
        op_sub          = 1'b0;
        res.status      = STAT_OK;
        res.slot        = cmd_slot_reg;
        res.fired       = 1'b0;
        res.finished    = 1'b0;
        res.reps        = '0;
        res.paused      = 1'b0;
        res.uptime      = uptime_reg;
        case (ctl.state)
            ST_UPTIME: begin
                // Advance uptime, wrapping
                op_a        = uptime_reg;
                uptime_next = op_sum;
            end
            ST_ADD: begin
                // Accumulate with saturation
                if (cur_use && !cur_pause) begin
                    tbl_we    = 1'b1;
                    tbl_acc_n = op_carry ? '1 : op_sum;
                end
            end
            ST_SUB: begin
                // Compare against period; on expiry subtract and count down
                op_sub = 1'b1;
                op_b   = cur_per;
                if (op_carry && !stall) begin
                    tbl_we    = 1'b1;
                    tbl_acc_n = fin ? '0 : op_sum;
                    tbl_rep_n = rep_new;
                    if (fin) begin
                        tbl_use_n   = 1'b0;
                        tbl_pause_n = 1'b0;
                    end
                    if (pend_valid_reg) begin
                        out_load = 1'b1;
                    end
                    res.slot        = SLOT_W'(ctl.idx);
                    res.fired       = 1'b1;
                    res.finished    = fin;
                    res.reps        = rep_new;
                    pend_next       = res;
                    pend_valid_next = 1'b1;
                end
            end
            ST_FIND: begin
                // Take the lowest free slot; reject a zero period, report full if none is free
                res.slot = '0;
                if (period_zero) begin
                    res.status      = STAT_REJECT;
                    pend_next       = res;
                    pend_valid_next = 1'b1;
                end else if (!cur_use) begin
                    tbl_we          = 1'b1;
                    tbl_use_n       = 1'b1;
                    tbl_pause_n     = 1'b0;
                    tbl_acc_n       = '0;
                    tbl_per_n       = period_reg;
                    tbl_rep_n       = reps_reg;
                    res.slot        = SLOT_W'(ctl.idx);
                    res.reps        = reps_reg;
                    pend_next       = res;
                    pend_valid_next = 1'b1;
                end else if (ctl.idx_end) begin
                    res.status      = STAT_FULL;
                    pend_next       = res;
                    pend_valid_next = 1'b1;
                end
            end
            ST_EXEC: begin
                // Apply a slot command
                pend_valid_next = 1'b1;
                if (cmd_reg > CMD_QUERY) begin
                    res.status = STAT_REJECT;
                end else if (!(slot_ok && cur_use)) begin
                    res.status = STAT_NOT_IN_USE;
                end else begin
                    case (cmd_reg)
                        CMD_DETACH: begin
                            tbl_we      = 1'b1;
                            tbl_use_n   = 1'b0;
                            tbl_pause_n = 1'b0;
                            tbl_acc_n   = '0;
                        end
                        CMD_PAUSE: begin
                            tbl_we      = 1'b1;
                            tbl_pause_n = 1'b1;
                        end
                        CMD_RESUME: begin
                            tbl_we      = 1'b1;
                            tbl_pause_n = 1'b0;
                        end
                        CMD_RESTART: begin
                            tbl_we    = 1'b1;
                            tbl_acc_n = '0;
                        end
                        CMD_CHANGE_PERIOD: begin
                            if (period_zero) begin
                                res.status = STAT_REJECT;
                            end else begin
                                tbl_we    = 1'b1;
                                tbl_acc_n = '0;
                                tbl_per_n = period_reg;
                            end
                        end
                        CMD_SET_REPEATS: begin
                            tbl_we    = 1'b1;
                            tbl_rep_n = reps_reg;
                        end
                        default: begin
                        end
                    endcase
                    res.reps   = tbl_rep_n;
                    res.paused = (cmd_reg == CMD_DETACH) ? 1'b0 : tbl_pause_n;
                end
                pend_next = res;
            end
            ST_FLUSH: begin
                // Release the staged item as the final one
                if (pend_valid_reg && out_free) begin
                    out_load        = 1'b1;
                    out_last        = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    // Hold control flags and uptime
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg     <= '0;
            paused_reg     <= '0;
            uptime_reg     <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (tbl_we) begin
                in_use_reg[rd_idx] <= tbl_use_n;
                paused_reg[rd_idx] <= tbl_pause_n;
            end
            uptime_reg     <= uptime_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Write table payload
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            acc_reg[rd_idx] <= tbl_acc_n;
            per_reg[rd_idx] <= tbl_per_n;
            rep_reg[rd_idx] <= tbl_rep_n;
        end
    end

    // Capture the item and move staged results
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= s_command;
            cmd_slot_reg <= s_slot;
            period_reg   <= s_period_ms;
            reps_reg     <= s_repeat_count;
            elapsed_reg  <= s_elapsed_ms;
        end
        pend_reg <= pend_next;
        if (out_load) begin
            out_reg      <= pend_reg;
            out_last_reg <= out_last;
        end
    end

    assign s_ready        = ctl.ready;
    assign m_valid        = m_valid_reg;
    assign m_status       = out_reg.status;
    assign m_timer_slot   = out_reg.slot;
    assign m_fired        = out_reg.fired;
    assign m_finished     = out_reg.finished;
    assign m_repeats_left = out_reg.reps;
    assign m_is_paused    = out_reg.paused;
    assign m_uptime_ms    = out_reg.uptime;
    assign m_last         = out_last_reg;

`ifndef NO_ASSERTIONS
    // Nothing stays staged once the block takes new items
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.ready |-> !pend_valid_reg)
        else $error("staged item left behind at idle");

    // An expiry is always ok and never reports a paused slot
    a_fire_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fired) |-> (m_status == STAT_OK && !m_is_paused))
        else $error("expiry item with bad status or pause flag");

    // Finish only comes with an expiry that used the last repeat
    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_finished) |-> (m_fired && m_repeats_left == '0))
        else $error("finish without final expiry");
`endif

endmodule

// File: hw/rtl/mspt_addsub.sv
// Shared 32-bit adder/subtractor with carry out (no borrow on subtract).
module mspt_addsub (
    input  logic [mspt_pkg::TIME_W-1:0] op_a,
    input  logic [mspt_pkg::TIME_W-1:0] op_b,
    input  logic                        op_sub,
    output logic [mspt_pkg::TIME_W-1:0] op_sum,
    output logic                        op_carry
);
    import mspt_pkg::*;

    logic [TIME_W:0] total;

    // Add, or add the complement plus one to subtract
    assign total = {1'b0, op_a} + {1'b0, op_b ^ {TIME_W{op_sub}}}
                 + {{TIME_W{1'b0}}, op_sub};
    assign op_sum   = total[TIME_W-1:0];
    assign op_carry = total[TIME_W];

endmodule

// File: hw/rtl/mspt_seq.sv
// Sequencer: command state machine and slot index counter.
module mspt_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  mspt_pkg::seq_sts_t  sts,
    output mspt_pkg::seq_ctl_t  ctl
);
    import mspt_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             idx_end;

    assign idx_end = (idx_reg == IDX_W'(SLOTS - 1));

    // Hold state and index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state and index
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (sts.in_valid) begin
                    if (sts.cmd_tick) begin
                        state_next = ST_UPTIME;
                    end else if (sts.cmd_attach) begin
                        state_next = ST_FIND;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_UPTIME: begin
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (sts.live) begin
                    state_next = ST_SUB;
                end else if (idx_end) begin
                    state_next = ST_FLUSH;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SUB: begin
                if (!(sts.fire && sts.stall)) begin
                    if (idx_end) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_ADD;
                    end
                end
            end
            ST_FIND: begin
                if (sts.find_hit || idx_end) begin
                    state_next = ST_FLUSH;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EXEC: begin
                state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!sts.pend_valid || sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive control outputs
    always_comb begin
        ctl.state   = state_reg;
        ctl.idx     = idx_reg;
        ctl.idx_end = idx_end;
        ctl.ready   = (state_reg == ST_IDLE);
    end

endmodule
